// File: rtl/ttsm_pkg.sv
`default_nettype none

package ttsm_pkg;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALPHA   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TIMEOUT = 4'd1;

  localparam logic [16:0] ALPHA_RESET   = 17'd19661;
  localparam logic [16:0] ALPHA_ONE     = 17'h10000;
  localparam logic [15:0] TIMEOUT_RESET = 16'd200;

  localparam logic [2:0] MODE_FRAME     = 3'd0;
  localparam logic [2:0] MODE_TICK      = 3'd1;
  localparam logic [2:0] MODE_INJECT    = 3'd2;
  localparam logic [2:0] MODE_SET_READY = 3'd3;
  localparam logic [2:0] MODE_FETCH     = 3'd4;

  typedef enum logic [2:0] {
    OP_FRAME,
    OP_TICK,
    OP_INJECT,
    OP_SET_READY,
    OP_FETCH,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] frame_seq;
    logic [31:0] time_ms;
    logic        ready_flag;
  } in_word_t;

  typedef struct packed {
    logic        target_valid;
    logic        target_fresh;
    logic [15:0] raw_x_out;
    logic [15:0] raw_y_out;
    logic [15:0] smooth_x_out;
    logic [15:0] smooth_y_out;
    logic [15:0] seq_out;
    logic        fetch_ok;
  } out_word_t;

  typedef struct packed {
    op_e      op;
    in_word_t word;
  } cmd_t;

  typedef struct packed {
    logic [16:0] smooth_alpha;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/ttsm_front.sv
`default_nettype none

module ttsm_front (
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  ttsm_pkg::in_word_t  in_word_i,
  input  ttsm_pkg::q_stat_t   q_stat_i,
  output logic                push_o,
  output ttsm_pkg::cmd_t      cmd_o
);

  ttsm_pkg::op_e op;

  always_comb begin
    unique case (in_word_i.mode)
      ttsm_pkg::MODE_FRAME:     op = ttsm_pkg::OP_FRAME;
      ttsm_pkg::MODE_TICK:      op = ttsm_pkg::OP_TICK;
      ttsm_pkg::MODE_INJECT:    op = ttsm_pkg::OP_INJECT;
      ttsm_pkg::MODE_SET_READY: op = ttsm_pkg::OP_SET_READY;
      ttsm_pkg::MODE_FETCH:     op = ttsm_pkg::OP_FETCH;
      default:                  op = ttsm_pkg::OP_NONE;
    endcase
  end

  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;
  assign cmd_o.op   = op;
  assign cmd_o.word = in_word_i;

endmodule

`default_nettype wire

// File: rtl/ttsm_queue.sv
`default_nettype none

module ttsm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  ttsm_pkg::cmd_t     cmd_i,
  input  wire                pop_i,
  output ttsm_pkg::cmd_t     cmd_o,
  output ttsm_pkg::q_stat_t  q_stat_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ttsm_pkg::cmd_t mem_q [DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign q_stat_o.full  = (count_q == CNT_W'(DEPTH));
  assign q_stat_o.avail = (count_q != '0);
  assign do_push        = push_i && !q_stat_o.full;
  assign do_pop         = pop_i && q_stat_o.avail;
  assign cmd_o          = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

`default_nettype wire

// File: rtl/ttsm_back.sv
`default_nettype none

module ttsm_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  ttsm_pkg::cfg_t      cfg_i,
  input  ttsm_pkg::q_stat_t   q_stat_i,
  input  ttsm_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ttsm_pkg::out_word_t out_word_o
);

  function automatic logic [31:0] ema_step(logic [31:0] f, logic [15:0] sample,
                                           logic [16:0] alpha);
    logic [31:0] s;
    logic [31:0] mag;
    logic [48:0] prod;
    logic [31:0] d;
    logic        up;
    s    = {sample, 16'h0000};
    up   = (s >= f);
    mag  = up ? (s - f) : (f - s);
    prod = 49'(mag) * 49'(alpha);
    d    = prod[47:16];
    return up ? (f + d) : (f - d);
  endfunction

  logic        valid_q, valid_d;
  logic        fresh_q, fresh_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] raw_x_q, raw_x_d;
  logic [15:0] raw_y_q, raw_y_d;
  logic [31:0] smooth_x_q, smooth_x_d;
  logic [31:0] smooth_y_q, smooth_y_d;
  logic [31:0] last_time_q, last_time_d;
  logic        out_valid_q;
  ttsm_pkg::out_word_t out_word_q, out_word_d;

  logic [16:0] alpha;
  logic [31:0] elapsed;
  logic        ok;

  assign pop_o   = q_stat_i.avail && (!out_valid_q || !out_stall_i);
  assign alpha   = (cfg_i.smooth_alpha > ttsm_pkg::ALPHA_ONE) ? ttsm_pkg::ALPHA_ONE
                                                              : cfg_i.smooth_alpha;
  assign elapsed = cmd_i.word.time_ms - last_time_q;

  always_comb begin
    valid_d     = valid_q;
    fresh_d     = fresh_q;
    seq_d       = seq_q;
    raw_x_d     = raw_x_q;
    raw_y_d     = raw_y_q;
    smooth_x_d  = smooth_x_q;
    smooth_y_d  = smooth_y_q;
    last_time_d = last_time_q;
    ok          = 1'b0;
    unique case (cmd_i.op)
      ttsm_pkg::OP_FRAME: begin
        raw_x_d     = cmd_i.word.pos_x;
        raw_y_d     = cmd_i.word.pos_y;
        seq_d       = cmd_i.word.frame_seq;
        last_time_d = cmd_i.word.time_ms;
        valid_d     = 1'b1;
        fresh_d     = 1'b1;
        if (smooth_x_q == '0 && smooth_y_q == '0) begin
          smooth_x_d = {cmd_i.word.pos_x, 16'h0000};
          smooth_y_d = {cmd_i.word.pos_y, 16'h0000};
        end else begin
          smooth_x_d = ema_step(smooth_x_q, cmd_i.word.pos_x, alpha);
          smooth_y_d = ema_step(smooth_y_q, cmd_i.word.pos_y, alpha);
        end
      end
      ttsm_pkg::OP_TICK: begin
        if (valid_q && (elapsed > {16'h0000, cfg_i.timeout_ms})) begin
          valid_d = 1'b0;
          fresh_d = 1'b0;
        end
      end
      ttsm_pkg::OP_INJECT: begin
        raw_x_d     = cmd_i.word.pos_x;
        raw_y_d     = cmd_i.word.pos_y;
        smooth_x_d  = {cmd_i.word.pos_x, 16'h0000};
        smooth_y_d  = {cmd_i.word.pos_y, 16'h0000};
        valid_d     = 1'b1;
        fresh_d     = 1'b1;
        last_time_d = cmd_i.word.time_ms;
      end
      ttsm_pkg::OP_SET_READY: begin
        fresh_d = cmd_i.word.ready_flag;
        if (!cmd_i.word.ready_flag) begin
          valid_d = 1'b0;
        end
      end
      ttsm_pkg::OP_FETCH: begin
        if (valid_q) begin
          ok      = 1'b1;
          fresh_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_word_d.target_valid = valid_d;
    out_word_d.target_fresh = fresh_d;
    out_word_d.raw_x_out    = raw_x_d;
    out_word_d.raw_y_out    = raw_y_d;
    out_word_d.smooth_x_out = smooth_x_d[31:16];
    out_word_d.smooth_y_out = smooth_y_d[31:16];
    out_word_d.seq_out      = seq_d;
    out_word_d.fetch_ok     = ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      fresh_q     <= 1'b0;
      seq_q       <= '0;
      raw_x_q     <= '0;
      raw_y_q     <= '0;
      smooth_x_q  <= '0;
      smooth_y_q  <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q     <= valid_d;
        fresh_q     <= fresh_d;
        seq_q       <= seq_d;
        raw_x_q     <= raw_x_d;
        raw_y_q     <= raw_y_d;
        smooth_x_q  <= smooth_x_d;
        smooth_y_q  <= smooth_y_d;
        last_time_q <= last_time_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_fetch_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.fetch_ok |-> out_word_o.target_valid)
    else $error("fetch reported without a valid target");

  a_frame_sets_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && cmd_i.op == ttsm_pkg::OP_FRAME |=> valid_q && fresh_q)
    else $error("frame did not set valid and fresh");

endmodule

`default_nettype wire

// File: rtl/target_track_smoother_unit.sv
// Vision target tracker with exponential smoothing and frame timeout.
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per item;
// mode selects frame, tick, inject, set ready or fetch. Every accepted
// word yields exactly one result word on the output channel
// (out_valid_o / out_stall_i / out_word_o), in order.
// Config channel (cfg_valid_i / cfg_ready_o): index 0 smooth_alpha,
// index 1 timeout_ms, other indexes ignored; ready is always high.
// A result is registered as its word leaves the queue. Throughput: one word
// per cycle while the receiver does not stall, set by the combinational
// filter update (one 32x17 multiply per axis) that carries the state to
// the next word. Words wait in a QUEUE_DEPTH-entry queue; while the
// receiver stalls the queue fills and in_stall_o rises once it is full.
// Reset: alpha 19661, timeout 200 ms, all track state zero, queue empty,
// no result pending.
`default_nettype none

module target_track_smoother_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  ttsm_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output ttsm_pkg::out_word_t                  out_word_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [ttsm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [ttsm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  ttsm_pkg::cfg_t    cfg_q;
  ttsm_pkg::q_stat_t q_stat;
  ttsm_pkg::cmd_t    push_cmd, head_cmd;
  logic              push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smooth_alpha <= ttsm_pkg::ALPHA_RESET;
      cfg_q.timeout_ms   <= ttsm_pkg::TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ttsm_pkg::CFG_IDX_ALPHA:   cfg_q.smooth_alpha <= cfg_data_i[16:0];
        ttsm_pkg::CFG_IDX_TIMEOUT: cfg_q.timeout_ms   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  ttsm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ttsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .cmd_o    (head_cmd),
    .q_stat_o (q_stat)
  );

  ttsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned IDX_W = ttsm_pkg::CFG_IDX_W;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE_FIRST = ttsm_pkg::CFG_IDX_TIMEOUT + 1'b1;
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE_LAST  = '1;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_WORDS   = 240;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  ttsm_pkg::in_word_t              in_word_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  ttsm_pkg::out_word_t             out_word_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [IDX_W-1:0]                cfg_index_i = '0;
  logic [ttsm_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // tracker state as the block should hold it
  ttsm_pkg::cfg_t track_cfg = '{smooth_alpha: ttsm_pkg::ALPHA_RESET,
                                timeout_ms: ttsm_pkg::TIMEOUT_RESET};
  logic        trk_valid   = 1'b0;
  logic        trk_fresh   = 1'b0;
  logic [15:0] trk_seq     = '0;
  logic [15:0] trk_raw_x   = '0;
  logic [15:0] trk_raw_y   = '0;
  logic [31:0] trk_fx      = '0;
  logic [31:0] trk_fy      = '0;
  logic [31:0] trk_last_ms = '0;

  ttsm_pkg::out_word_t pending_reports[$];
  ttsm_pkg::out_word_t head_report;

  int unsigned error_count     = 0;
  int unsigned words_sent      = 0;
  int unsigned frames_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned blocked_cycles  = 0;
  int unsigned settings_used   = 0;

  int unsigned hold_request = 0;
  int unsigned hold_left    = 0;
  int unsigned stall_pct    = 0;
  int unsigned stall_run    = 0;
  logic        stall_state  = 1'b0;

  logic [31:0] now_ms      = 32'hFFFF_F000;
  logic [15:0] seq_counter = '0;

  target_track_smoother_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [31:0] ema_next(logic [31:0] f, logic [15:0] sample);
    logic [63:0] s;
    logic [63:0] f64;
    logic [63:0] step;
    logic [16:0] a;
    a = (track_cfg.smooth_alpha > ttsm_pkg::ALPHA_ONE) ? ttsm_pkg::ALPHA_ONE
                                                       : track_cfg.smooth_alpha;
    s = {32'd0, sample, 16'd0};
    f64 = {32'd0, f};
    if (s >= f64) begin
      step = ((s - f64) * a) >> 16;
      return f + step[31:0];
    end
    step = ((f64 - s) * a) >> 16;
    return f - step[31:0];
  endfunction

  function automatic ttsm_pkg::out_word_t track_update(ttsm_pkg::in_word_t w);
    ttsm_pkg::out_word_t r;
    logic [31:0]         since;
    r = '0;
    case (w.mode)
      ttsm_pkg::MODE_FRAME: begin
        trk_raw_x   = w.pos_x;
        trk_raw_y   = w.pos_y;
        trk_seq     = w.frame_seq;
        trk_last_ms = w.time_ms;
        trk_valid   = 1'b1;
        trk_fresh   = 1'b1;
        if (trk_fx == '0 && trk_fy == '0) begin
          trk_fx = {w.pos_x, 16'd0};
          trk_fy = {w.pos_y, 16'd0};
        end else begin
          trk_fx = ema_next(trk_fx, w.pos_x);
          trk_fy = ema_next(trk_fy, w.pos_y);
        end
      end
      ttsm_pkg::MODE_TICK: begin
        since = w.time_ms - trk_last_ms;
        if (trk_valid && since > {16'd0, track_cfg.timeout_ms}) begin
          trk_valid = 1'b0;
          trk_fresh = 1'b0;
        end
      end
      ttsm_pkg::MODE_INJECT: begin
        trk_raw_x   = w.pos_x;
        trk_raw_y   = w.pos_y;
        trk_fx      = {w.pos_x, 16'd0};
        trk_fy      = {w.pos_y, 16'd0};
        trk_valid   = 1'b1;
        trk_fresh   = 1'b1;
        trk_last_ms = w.time_ms;
      end
      ttsm_pkg::MODE_SET_READY: begin
        trk_fresh = w.ready_flag;
        if (!w.ready_flag) begin
          trk_valid = 1'b0;
        end
      end
      ttsm_pkg::MODE_FETCH: begin
        if (trk_valid) begin
          r.fetch_ok = 1'b1;
          trk_fresh  = 1'b0;
        end
      end
      default: ;
    endcase
    r.target_valid = trk_valid;
    r.target_fresh = trk_fresh;
    r.raw_x_out    = trk_raw_x;
    r.raw_y_out    = trk_raw_y;
    r.smooth_x_out = trk_fx[31:16];
    r.smooth_y_out = trk_fy[31:16];
    r.seq_out      = trk_seq;
    return r;
  endfunction

  // receiver: random stall runs, or a long hold when asked
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_state = ($urandom_range(99) < stall_pct);
        stall_run = $urandom_range(1, 6);
      end
      stall_run--;
      out_stall_i <= stall_state;
    end
  end

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) begin
      blocked_cycles++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word: expected none, actual %p", $time, out_word_o);
      end else begin
        head_report = pending_reports.pop_front();
        compare_field("target_valid", 16'(head_report.target_valid),
                      16'(out_word_o.target_valid));
        compare_field("target_fresh", 16'(head_report.target_fresh),
                      16'(out_word_o.target_fresh));
        compare_field("raw_x_out", head_report.raw_x_out, out_word_o.raw_x_out);
        compare_field("raw_y_out", head_report.raw_y_out, out_word_o.raw_y_out);
        compare_field("smooth_x_out", head_report.smooth_x_out, out_word_o.smooth_x_out);
        compare_field("smooth_y_out", head_report.smooth_y_out, out_word_o.smooth_y_out);
        compare_field("seq_out", head_report.seq_out, out_word_o.seq_out);
        compare_field("fetch_ok", 16'(head_report.fetch_ok), 16'(out_word_o.fetch_ok));
        results_checked++;
      end
    end
  end

  task automatic send_word(ttsm_pkg::in_word_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    pending_reports.push_back(track_update(w));
    words_sent++;
    if (w.mode == ttsm_pkg::MODE_FRAME) begin
      frames_sent++;
    end
  endtask

  task automatic send_fields(logic [2:0] mode, logic [15:0] x, logic [15:0] y,
                             logic [15:0] seq, logic [31:0] t, logic rdy);
    ttsm_pkg::in_word_t w;
    w.mode       = mode;
    w.pos_x      = x;
    w.pos_y      = y;
    w.frame_seq  = seq;
    w.time_ms    = t;
    w.ready_flag = rdy;
    send_word(w);
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles == 0) begin
      return;
    end
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [ttsm_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    if (idx == ttsm_pkg::CFG_IDX_ALPHA) begin
      track_cfg.smooth_alpha = data[16:0];
    end else if (idx == ttsm_pkg::CFG_IDX_TIMEOUT) begin
      track_cfg.timeout_ms = data[15:0];
    end
  endtask

  task automatic apply_setting(logic [31:0] alpha, logic [31:0] timeout);
    drain_results();
    write_reg(ttsm_pkg::CFG_IDX_ALPHA, alpha);
    write_reg(IDX_W'($urandom_range(CFG_IDX_SPARE_FIRST, CFG_IDX_SPARE_LAST)), $urandom);
    write_reg(ttsm_pkg::CFG_IDX_TIMEOUT, timeout);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // mostly a plausible track: advancing time, rising sequence numbers,
  // positions near the last one; some words are pure noise
  function automatic ttsm_pkg::in_word_t random_word();
    ttsm_pkg::in_word_t w;
    int unsigned        pick;
    pick = $urandom_range(99);
    now_ms = now_ms + $urandom_range(30);
    w.mode       = ttsm_pkg::MODE_FRAME;
    w.pos_x      = trk_raw_x + 16'($urandom_range(64)) - 16'd32;
    w.pos_y      = trk_raw_y + 16'($urandom_range(64)) - 16'd32;
    w.frame_seq  = 16'($urandom);
    w.time_ms    = $urandom;
    w.ready_flag = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) begin
      w.pos_x = 16'($urandom);
      w.pos_y = 16'($urandom);
    end
    if (pick < 40) begin
      seq_counter++;
      if ($urandom_range(9) != 0) begin
        w.frame_seq = seq_counter;
      end
      if ($urandom_range(19) != 0) begin
        w.time_ms = now_ms;
      end
    end else if (pick < 60) begin
      w.mode = ttsm_pkg::MODE_TICK;
      case ($urandom_range(3))
        0: w.time_ms = now_ms;
        1: w.time_ms = trk_last_ms + track_cfg.timeout_ms;
        2: w.time_ms = trk_last_ms + track_cfg.timeout_ms + 1'b1;
        default: ;
      endcase
    end else if (pick < 68) begin
      w.mode = ttsm_pkg::MODE_INJECT;
      w.time_ms = now_ms;
      if ($urandom_range(4) == 0) begin
        w.pos_x = '0;
        w.pos_y = '0;
      end
    end else if (pick < 76) begin
      w.mode = ttsm_pkg::MODE_SET_READY;
    end else if (pick < 94) begin
      w.mode = ttsm_pkg::MODE_FETCH;
    end else begin
      w.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    end
    return w;
  endfunction

  task automatic send_stream(int unsigned count, int unsigned max_gap);
    int unsigned burst;
    burst = 0;
    repeat (count) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        idle_for($urandom_range(0, max_gap));
      end
      burst--;
      send_word(random_word());
    end
  endtask

  task automatic test_directed_cases();
    stall_pct = 0;
    send_fields(ttsm_pkg::MODE_FETCH, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000, 1'b1);
    send_fields(ttsm_pkg::MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_fields(ttsm_pkg::MODE_FRAME, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0);
    send_fields(ttsm_pkg::MODE_FRAME, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd100, 1'b1);
    send_fields(ttsm_pkg::MODE_FRAME, 16'h0000, 16'h0000, 16'h0001, 32'd150, 1'b0);
    send_fields(ttsm_pkg::MODE_FRAME, 16'h1234, 16'hFFFF, 16'h0002, 32'd200, 1'b0);
    send_fields(ttsm_pkg::MODE_TICK, 16'h0000, 16'h0000, 16'h0000,
                32'd200 + ttsm_pkg::TIMEOUT_RESET, 1'b0);
    send_fields(ttsm_pkg::MODE_TICK, 16'h0000, 16'h0000, 16'h0000,
                32'd201 + ttsm_pkg::TIMEOUT_RESET, 1'b0);
    send_fields(ttsm_pkg::MODE_FETCH, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0);
    send_fields(ttsm_pkg::MODE_INJECT, 16'h0000, 16'h0000, 16'hFFFF, 32'hFFFF_FFF0, 1'b1);
    send_fields(ttsm_pkg::MODE_FRAME, 16'hABCD, 16'h0000, 16'h8000, 32'hFFFF_FFF0, 1'b0);
    send_fields(ttsm_pkg::MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0010, 1'b1);
    send_fields(ttsm_pkg::MODE_TICK, 16'h0000, 16'h0000, 16'h0000, 32'hFFFF_FFEF, 1'b1);
    send_fields(ttsm_pkg::MODE_SET_READY, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b1);
    send_fields(ttsm_pkg::MODE_FETCH, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b1);
    send_fields(ttsm_pkg::MODE_INJECT, 16'hFFFF, 16'hFFFF, 16'h0000, 32'h8000_0000, 1'b0);
    send_fields(ttsm_pkg::MODE_FETCH, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0);
    send_fields(ttsm_pkg::MODE_FETCH, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    send_fields(ttsm_pkg::MODE_SET_READY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                1'b0);
    send_fields(ttsm_pkg::MODE_INJECT, 16'h0001, 16'h0002, 16'h0000, 32'd5, 1'b1);
    send_fields(ttsm_pkg::MODE_SET_READY, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b1);
    for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
      send_fields(3'(m), 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
    end
    send_fields(ttsm_pkg::MODE_FETCH, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0);
    drain_results();
  endtask

  task automatic test_register_extremes();
    logic [31:0] alphas[6]   = '{32'd0, {15'd0, ttsm_pkg::ALPHA_ONE}, 32'hFFFF_FFFF,
                                 {15'd0, ttsm_pkg::ALPHA_ONE} + 32'd1, 32'd1, 32'd19661};
    logic [31:0] timeouts[6] = '{32'd0, 32'hFFFF, 32'd1, 32'hABCD_0005, 32'hFFFE, 32'd200};
    stall_pct = 30;
    for (int i = 0; i < 6; i++) begin
      apply_setting(alphas[i], timeouts[i]);
      send_stream(40, 3);
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [31:0] alpha;
    logic [31:0] timeout;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      alpha   = ($urandom_range(3) == 0) ? $urandom
                                         : $urandom_range(0, ttsm_pkg::ALPHA_ONE);
      timeout = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 400);
      apply_setting(alpha, timeout);
      if (p == 0) begin
        stall_pct = 0;
        send_stream(PHASE_WORDS, 0);
      end else begin
        stall_pct = (p % 2 == 0) ? 70 : 30;
        send_stream(PHASE_WORDS, (p % 3 == 0) ? 10 : 4);
      end
    end
    drain_results();
  endtask

  task automatic test_backpressure();
    stall_pct = 0;
    hold_request = 300;
    send_stream(60, 0);
    drain_results();
    stall_pct = 50;
    send_stream(30, 2);
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    drain_results();
    $display("covered %0d words (%0d frames), %0d results checked over %0d register settings",
             words_sent, frames_sent, results_checked, settings_used);
    $display("input held off by a full queue for %0d cycles", blocked_cycles);
    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
